// File: rtl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

    // map geometry
    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;
    localparam int WORD_BITS  = 32;

    localparam int MAP_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int PAGE_W     = WIDX_W + BIT_W;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // beat fields
    localparam int OPC_W    = 2;
    localparam int FIRST_W  = 15;
    localparam int COUNT_W  = 16;
    localparam int ADDR_W   = 27;
    localparam int STATUS_W = 2;

    localparam int OPC_LSB   = 0;
    localparam int FIRST_LSB = OPC_LSB + OPC_W;
    localparam int COUNT_LSB = FIRST_LSB + FIRST_W;
    localparam int ADDR_LSB  = COUNT_LSB + COUNT_W;
    localparam int IN_BITS   = ADDR_LSB + ADDR_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STATUS_W + ADDR_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    // range end arithmetic
    localparam int RAW_END_W = $clog2(NUM_PAGES + 1);
    localparam int END_W     = (RAW_END_W > COUNT_W + 1) ? RAW_END_W : COUNT_W + 1;

    // opcodes
    localparam logic [OPC_W-1:0] OP_ALLOC     = 2'd0;
    localparam logic [OPC_W-1:0] OP_FREE      = 2'd1;
    localparam logic [OPC_W-1:0] OP_MARK_USED = 2'd2;
    localparam logic [OPC_W-1:0] OP_MARK_FREE = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOM      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISALIGN = 2'd2;

    // what the word walk does to each word it reads
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ALLOC = 2'd0;
    localparam kind_t KIND_SET   = 2'd1;
    localparam kind_t KIND_CLR   = 2'd2;

    function automatic logic [ADDR_W-1:0] page_to_addr(input logic [PAGE_W-1:0] page);
        logic [63:0] wide;
        wide = 64'(page) << PAGE_SHIFT;
        return wide[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/bpa_ram.sv
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bitmap_page_allocator.sv
`default_nettype none

// First-fit page allocator over a bitmap held in one simple dual-port RAM of
// MAP_WORDS words (1024 x 32 bits by default), one bit per page, set = used.
// After reset the block sweeps the RAM once, writing every word to all ones;
// no input beat is taken during the sweep. One request is worked at a time: a
// single read-modify-write unit walks the map one word per cycle, the read of
// the next word overlapping the write of the current one. Allocate walks up
// from word 0 to the word that holds the lowest free page (the whole map when
// it is full), an aligned free reads and rewrites one word, a range update
// walks the words of its range, and mark-free then sets page zero again in a
// second pass. A misaligned free, a free outside the map and an empty
// mark-used finish in the accept cycle, and an empty mark-free only sets page
// zero. The result beat follows in the next cycle and is held until taken; a
// new input beat is accepted only after that.
module bitmap_page_allocator (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // opcode, first_page, page_count, free_address, zero pad
    input  wire logic [bpa_pkg::IN_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // status, page_address, zero pad
    output logic      [bpa_pkg::OUT_W-1:0]  m_tdata
);

    localparam int WB = bpa_pkg::WORD_BITS;
    localparam int WW = bpa_pkg::WIDX_W;
    localparam int BW = bpa_pkg::BIT_W;

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    localparam logic [WW-1:0] LAST_WORD = WW'(bpa_pkg::MAP_WORDS - 1);
    localparam logic [WB-1:0] ONES      = {WB{1'b1}};

    logic [1:0]                     state_reg, state_next;
    logic [WW-1:0]                  init_reg, init_next;
    logic [WW-1:0]                  idx_reg, idx_next;
    logic                           issue_reg, issue_next;
    logic                           chk_reg, chk_next;
    logic [WW-1:0]                  chk_addr_reg, chk_addr_next;
    bpa_pkg::kind_t                 kind_reg, kind_next;
    logic                           fix_reg, fix_next;
    logic [WW-1:0]                  lo_word_reg, lo_word_next;
    logic [WW-1:0]                  hi_word_reg, hi_word_next;
    logic [BW-1:0]                  lo_bit_reg, lo_bit_next;
    logic [BW-1:0]                  hi_bit_reg, hi_bit_next;
    logic                           out_valid_reg, out_valid_next;
    logic [bpa_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [bpa_pkg::ADDR_W-1:0]     addr_reg, addr_next;

    logic                           ram_wr_en;
    logic [WW-1:0]                  ram_wr_addr;
    logic [WB-1:0]                  ram_wr_data;
    logic                           ram_rd_en;
    logic [WB-1:0]                  ram_rd_data;

    logic                           run_wr;
    logic [WB-1:0]                  run_wr_data;

    // request decode
    logic [bpa_pkg::OPC_W-1:0]      in_opc;
    logic [bpa_pkg::FIRST_W-1:0]    in_first;
    logic [bpa_pkg::COUNT_W-1:0]    in_count;
    logic [bpa_pkg::ADDR_W-1:0]     in_addr;
    logic                           in_aligned;
    logic [63:0]                    free_page;
    logic                           free_in_map;
    logic [bpa_pkg::END_W-1:0]      range_end;
    logic [bpa_pkg::END_W-1:0]      range_endc;
    logic                           range_nonempty;
    logic [63:0]                    first_w;
    logic [63:0]                    last_w;

    // word walk
    logic [WB-1:0]                  lo_mask;
    logic [WB-1:0]                  hi_mask;
    logic [WB-1:0]                  word_mask;
    logic                           found;
    logic [BW-1:0]                  found_bit;
    logic                           at_last;

    assign in_opc   = s_tdata[bpa_pkg::OPC_LSB   +: bpa_pkg::OPC_W];
    assign in_first = s_tdata[bpa_pkg::FIRST_LSB +: bpa_pkg::FIRST_W];
    assign in_count = s_tdata[bpa_pkg::COUNT_LSB +: bpa_pkg::COUNT_W];
    assign in_addr  = s_tdata[bpa_pkg::ADDR_LSB  +: bpa_pkg::ADDR_W];

    assign in_aligned  = (in_addr & bpa_pkg::ADDR_W'(bpa_pkg::PAGE_BYTES - 1))
                         == '0;
    assign free_page   = 64'(in_addr) >> bpa_pkg::PAGE_SHIFT;
    assign free_in_map = free_page < 64'(bpa_pkg::NUM_PAGES);

    // range end clamped to the map, never wrapping
    assign range_end      = bpa_pkg::END_W'(in_first) + bpa_pkg::END_W'(in_count);
    assign range_endc     = (range_end > bpa_pkg::END_W'(bpa_pkg::NUM_PAGES))
                            ? bpa_pkg::END_W'(bpa_pkg::NUM_PAGES) : range_end;
    assign range_nonempty = range_endc > bpa_pkg::END_W'(in_first);
    assign first_w        = 64'(in_first);
    assign last_w         = 64'(range_endc - bpa_pkg::END_W'(1));

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bpa_pkg::OUT_W'({addr_reg, status_reg});

    // bit masks for the partial words at either end of a range
    assign lo_mask   = (chk_addr_reg == lo_word_reg) ? (ONES << lo_bit_reg) : ONES;
    assign hi_mask   = (chk_addr_reg == hi_word_reg)
                       ? (ONES >> (BW'(WB - 1) - hi_bit_reg)) : ONES;
    assign word_mask = lo_mask & hi_mask;
    assign at_last   = chk_addr_reg == hi_word_reg;

    // lowest clear bit of the word just read
    always_comb
    begin
        found     = 1'b0;
        found_bit = '0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (!ram_rd_data[i])
            begin
                found     = 1'b1;
                found_bit = BW'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        chk_next       = chk_reg;
        chk_addr_next  = chk_addr_reg;
        kind_next      = kind_reg;
        fix_next       = fix_reg;
        lo_word_next   = lo_word_reg;
        hi_word_next   = hi_word_reg;
        lo_bit_next    = lo_bit_reg;
        hi_bit_next    = hi_bit_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        addr_next      = addr_reg;
        run_wr         = 1'b0;
        run_wr_data    = ram_rd_data;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                if (init_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_next = init_reg + WW'(1);
                end
            end

            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    idx_next    = '0;
                    issue_next  = 1'b1;
                    chk_next    = 1'b0;
                    fix_next    = 1'b0;
                    status_next = bpa_pkg::STATUS_OK;
                    addr_next   = '0;
                    case (in_opc)
                        bpa_pkg::OP_ALLOC:
                        begin
                            kind_next    = bpa_pkg::KIND_ALLOC;
                            lo_word_next = '0;
                            hi_word_next = LAST_WORD;
                            state_next   = S_RUN;
                        end
                        bpa_pkg::OP_FREE:
                        begin
                            if (!in_aligned)
                            begin
                                status_next    = bpa_pkg::STATUS_MISALIGN;
                                out_valid_next = 1'b1;
                            end
                            else if (!free_in_map)
                            begin
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                kind_next    = bpa_pkg::KIND_CLR;
                                lo_word_next = free_page[BW +: WW];
                                hi_word_next = free_page[BW +: WW];
                                lo_bit_next  = free_page[BW-1:0];
                                hi_bit_next  = free_page[BW-1:0];
                                idx_next     = free_page[BW +: WW];
                                state_next   = S_RUN;
                            end
                        end
                        bpa_pkg::OP_MARK_USED,
                        bpa_pkg::OP_MARK_FREE:
                        begin
                            fix_next = in_opc == bpa_pkg::OP_MARK_FREE;
                            if (range_nonempty)
                            begin
                                kind_next    = (in_opc == bpa_pkg::OP_MARK_FREE)
                                               ? bpa_pkg::KIND_CLR : bpa_pkg::KIND_SET;
                                lo_word_next = first_w[BW +: WW];
                                hi_word_next = last_w[BW +: WW];
                                lo_bit_next  = first_w[BW-1:0];
                                hi_bit_next  = last_w[BW-1:0];
                                idx_next     = first_w[BW +: WW];
                                state_next   = S_RUN;
                            end
                            else if (in_opc == bpa_pkg::OP_MARK_FREE)
                            begin
                                // empty range still re-reserves page zero
                                fix_next     = 1'b0;
                                kind_next    = bpa_pkg::KIND_SET;
                                lo_word_next = '0;
                                hi_word_next = '0;
                                lo_bit_next  = '0;
                                hi_bit_next  = '0;
                                state_next   = S_RUN;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            S_RUN:
            begin
                // read side runs one word ahead of the check side
                chk_next      = issue_reg;
                chk_addr_next = idx_reg;
                if (issue_reg)
                begin
                    if (idx_reg == hi_word_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + WW'(1);
                    end
                end

                if (chk_reg)
                begin
                    case (kind_reg)
                        bpa_pkg::KIND_ALLOC:
                        begin
                            if (found)
                            begin
                                run_wr         = 1'b1;
                                run_wr_data    = ram_rd_data | (WB'(1) << found_bit);
                                status_next    = bpa_pkg::STATUS_OK;
                                addr_next      = bpa_pkg::page_to_addr({chk_addr_reg,
                                                                        found_bit});
                                out_valid_next = 1'b1;
                                state_next     = S_IDLE;
                                issue_next     = 1'b0;
                                chk_next       = 1'b0;
                            end
                            else if (at_last)
                            begin
                                status_next    = bpa_pkg::STATUS_OOM;
                                out_valid_next = 1'b1;
                                state_next     = S_IDLE;
                                issue_next     = 1'b0;
                                chk_next       = 1'b0;
                            end
                        end
                        bpa_pkg::KIND_SET,
                        bpa_pkg::KIND_CLR:
                        begin
                            run_wr      = 1'b1;
                            run_wr_data = (kind_reg == bpa_pkg::KIND_SET)
                                          ? (ram_rd_data | word_mask)
                                          : (ram_rd_data & ~word_mask);
                            if (at_last)
                            begin
                                issue_next = 1'b0;
                                chk_next   = 1'b0;
                                if (fix_reg)
                                begin
                                    // second pass: set page zero again
                                    fix_next     = 1'b0;
                                    kind_next    = bpa_pkg::KIND_SET;
                                    lo_word_next = '0;
                                    hi_word_next = '0;
                                    lo_bit_next  = '0;
                                    hi_bit_next  = '0;
                                    idx_next     = '0;
                                    issue_next   = 1'b1;
                                end
                                else
                                begin
                                    out_valid_next = 1'b1;
                                    state_next     = S_IDLE;
                                end
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                            issue_next     = 1'b0;
                            chk_next       = 1'b0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ram_rd_en   = (state_reg == S_RUN) && issue_reg;
    assign ram_wr_en   = (state_reg == S_INIT) || run_wr;
    assign ram_wr_addr = (state_reg == S_INIT) ? init_reg : chk_addr_reg;
    assign ram_wr_data = (state_reg == S_INIT) ? ONES : run_wr_data;

    bpa_ram #(
        .WIDTH (WB),
        .DEPTH (bpa_pkg::MAP_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            issue_reg     <= 1'b0;
            chk_reg       <= 1'b0;
            fix_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            issue_reg     <= issue_next;
            chk_reg       <= chk_next;
            fix_reg       <= fix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        chk_addr_reg <= chk_addr_next;
        kind_reg     <= kind_next;
        lo_word_reg  <= lo_word_next;
        hi_word_reg  <= hi_word_next;
        lo_bit_reg   <= lo_bit_next;
        hi_bit_reg   <= hi_bit_next;
        status_reg   <= status_next;
        addr_reg     <= addr_next;
    end

endmodule

`default_nettype wire

// File: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 560;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int LONG_HOLD_AT  = 60;
    localparam int LONG_HOLD     = 2000;
    localparam int HOT_PAGES     = 2048;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [bpa_pkg::STATUS_W-1:0] status;
        logic [bpa_pkg::ADDR_W-1:0]   page_address;
    } alloc_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [bpa_pkg::IN_W-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [bpa_pkg::OUT_W-1:0] m_tdata;

    // shadow copy of the usage map, one bit per page, set = used
    bit [bpa_pkg::NUM_PAGES-1:0] page_map;

    logic [bpa_pkg::IN_W-1:0] pending_reqs[$];
    alloc_result_t            expected_results[$];

    int  sent_total = 0;
    int  results_seen = 0;
    int  errors = 0;
    int  cycle_count = 0;
    int  tx_wait = 0;
    int  tx_burst = 0;
    int  rx_wait = 0;
    int  rx_burst = 0;
    bit  req_taken = 1'b0;
    bit  rsp_taken = 1'b0;

    bitmap_page_allocator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [bpa_pkg::IN_W-1:0] make_request(
        input logic [bpa_pkg::OPC_W-1:0] opc,
        input int unsigned first_pg,
        input int unsigned page_cnt,
        input int unsigned byte_addr
    );
        logic [bpa_pkg::IN_W-1:0] beat;
        beat = '0;
        beat[bpa_pkg::OPC_LSB +: bpa_pkg::OPC_W]     = opc;
        beat[bpa_pkg::FIRST_LSB +: bpa_pkg::FIRST_W] = first_pg[bpa_pkg::FIRST_W-1:0];
        beat[bpa_pkg::COUNT_LSB +: bpa_pkg::COUNT_W] = page_cnt[bpa_pkg::COUNT_W-1:0];
        beat[bpa_pkg::ADDR_LSB +: bpa_pkg::ADDR_W]   = byte_addr[bpa_pkg::ADDR_W-1:0];
        return beat;
    endfunction

    // mostly works near the bottom of the map so first-fit scans stay short
    function automatic logic [bpa_pkg::IN_W-1:0] random_request();
        int unsigned pick;
        int unsigned first_pg;
        int unsigned page_cnt;
        int unsigned byte_addr;
        logic [bpa_pkg::OPC_W-1:0] opc;
        pick      = $urandom_range(0, 99);
        first_pg  = $urandom;
        page_cnt  = $urandom;
        byte_addr = $urandom;
        if (pick < 35)
            opc = bpa_pkg::OP_ALLOC;
        else if (pick < 62)
        begin
            opc = bpa_pkg::OP_FREE;
            if ($urandom_range(0, 9) != 0)
            begin
                if ($urandom_range(0, 6) != 0)
                    byte_addr = $urandom_range(0, HOT_PAGES - 1) * bpa_pkg::PAGE_BYTES;
                else
                    byte_addr = $urandom_range(0, bpa_pkg::NUM_PAGES - 1)
                                * bpa_pkg::PAGE_BYTES;
            end
        end
        else
        begin
            opc = (pick < 80) ? bpa_pkg::OP_MARK_USED : bpa_pkg::OP_MARK_FREE;
            if ($urandom_range(0, 6) != 0)
                first_pg = $urandom_range(0, HOT_PAGES - 1);
            if ($urandom_range(0, 39) != 0)
                page_cnt = $urandom_range(0, 48);
        end
        return make_request(opc, first_pg, page_cnt, byte_addr);
    endfunction

    function automatic alloc_result_t apply_request(input logic [bpa_pkg::IN_W-1:0] beat);
        logic [bpa_pkg::OPC_W-1:0]   opc;
        logic [bpa_pkg::FIRST_W-1:0] first_pg;
        logic [bpa_pkg::COUNT_W-1:0] page_cnt;
        logic [bpa_pkg::ADDR_W-1:0]  byte_addr;
        alloc_result_t               res;
        int                          p;
        int                          end_pg;
        bit                          found;
        opc       = beat[bpa_pkg::OPC_LSB +: bpa_pkg::OPC_W];
        first_pg  = beat[bpa_pkg::FIRST_LSB +: bpa_pkg::FIRST_W];
        page_cnt  = beat[bpa_pkg::COUNT_LSB +: bpa_pkg::COUNT_W];
        byte_addr = beat[bpa_pkg::ADDR_LSB +: bpa_pkg::ADDR_W];
        res.status       = bpa_pkg::STATUS_OK;
        res.page_address = '0;
        case (opc)
            bpa_pkg::OP_ALLOC:
            begin
                found = 1'b0;
                for (p = 0; p < bpa_pkg::NUM_PAGES && !found; p++)
                begin
                    if (!page_map[p])
                    begin
                        found = 1'b1;
                        page_map[p] = 1'b1;
                        res.page_address = bpa_pkg::ADDR_W'(p * bpa_pkg::PAGE_BYTES);
                    end
                end
                if (!found)
                    res.status = bpa_pkg::STATUS_OOM;
            end
            bpa_pkg::OP_FREE:
            begin
                if (byte_addr % bpa_pkg::PAGE_BYTES != 0)
                    res.status = bpa_pkg::STATUS_MISALIGN;
                else if (int'(byte_addr) / bpa_pkg::PAGE_BYTES < bpa_pkg::NUM_PAGES)
                    page_map[int'(byte_addr) / bpa_pkg::PAGE_BYTES] = 1'b0;
            end
            default:
            begin
                // range stops at the end of the map, no wrap
                end_pg = int'(first_pg) + int'(page_cnt);
                if (end_pg > bpa_pkg::NUM_PAGES)
                    end_pg = bpa_pkg::NUM_PAGES;
                for (p = int'(first_pg); p < end_pg; p++)
                    page_map[p] = (opc == bpa_pkg::OP_MARK_USED);
                if (opc == bpa_pkg::OP_MARK_FREE)
                    page_map[0] = 1'b1;
            end
        endcase
        return res;
    endfunction

    task automatic queue_request(input logic [bpa_pkg::IN_W-1:0] beat);
        pending_reqs.push_back(beat);
        sent_total++;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !req_taken))
        begin
            if (tx_wait > 0)
            begin
                s_tvalid <= 1'b0;
                tx_wait  <= tx_wait - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_reqs.pop_front();
                tx_wait  <= draw_wait(tx_burst);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver, one stall drawn per result beat
    always @(negedge clk)
    begin : rx_ctrl
        int hold;
        if (rsp_taken)
            hold = (results_seen == LONG_HOLD_AT) ? LONG_HOLD : draw_wait(rx_burst);
        else
            hold = rx_wait;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold > 0)
        begin
            m_tready <= 1'b0;
            rx_wait  <= hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_wait  <= 0;
        end
    end

    always @(posedge clk)
    begin : monitor
        alloc_result_t want;
        req_taken <= s_tvalid && s_tready;
        rsp_taken <= m_tvalid && m_tready;
        if (rst_n && s_tvalid && s_tready)
            expected_results.push_back(apply_request(s_tdata));
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $error("result beat with no request outstanding: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[0 +: bpa_pkg::STATUS_W] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status,
                           m_tdata[0 +: bpa_pkg::STATUS_W]);
                    errors++;
                end
                if (m_tdata[bpa_pkg::STATUS_W +: bpa_pkg::ADDR_W] !== want.page_address)
                begin
                    $error("page_address: expected %h, got %h", want.page_address,
                           m_tdata[bpa_pkg::STATUS_W +: bpa_pkg::ADDR_W]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        page_map = '1;

        // directed: full map, misaligned and aligned frees, ranges off the end
        queue_request(make_request(bpa_pkg::OP_ALLOC, 0, 0, 0));
        queue_request(make_request(bpa_pkg::OP_FREE, 0, 0, 'h0000801));
        queue_request(make_request(bpa_pkg::OP_FREE, 0, 0, 5 * bpa_pkg::PAGE_BYTES));
        queue_request(make_request(bpa_pkg::OP_ALLOC, 0, 0, 0));
        queue_request(make_request(bpa_pkg::OP_ALLOC, 'h7FFF, 'hFFFF, 'h7FFFFFF));
        queue_request(make_request(bpa_pkg::OP_FREE, 0, 0,
                                   (bpa_pkg::NUM_PAGES - 1) * bpa_pkg::PAGE_BYTES));
        queue_request(make_request(bpa_pkg::OP_ALLOC, 0, 0, 0));
        queue_request(make_request(bpa_pkg::OP_FREE, 'h7FFF, 'hFFFF, 'h7FFFFFF));
        queue_request(make_request(bpa_pkg::OP_MARK_FREE, 0, 0, 0));
        queue_request(make_request(bpa_pkg::OP_MARK_FREE, bpa_pkg::NUM_PAGES - 8,
                                   'hFFFF, 0));
        queue_request(make_request(bpa_pkg::OP_ALLOC, 0, 0, 0));
        queue_request(make_request(bpa_pkg::OP_MARK_FREE, 0, 'h8000, 0));
        queue_request(make_request(bpa_pkg::OP_ALLOC, 0, 0, 0));
        queue_request(make_request(bpa_pkg::OP_ALLOC, 0, 0, 0));
        queue_request(make_request(bpa_pkg::OP_MARK_USED, 0, 'hFFFF, 0));
        queue_request(make_request(bpa_pkg::OP_ALLOC, 0, 0, 0));
        queue_request(make_request(bpa_pkg::OP_MARK_FREE, 'h7FFF, 1, 0));
        queue_request(make_request(bpa_pkg::OP_MARK_USED, 'h7FFF, 0, 0));
        queue_request(make_request(bpa_pkg::OP_ALLOC, 0, 0, 0));
        queue_request(make_request(bpa_pkg::OP_FREE, 0, 0, 0));
        queue_request(make_request(bpa_pkg::OP_ALLOC, 0, 0, 0));
        queue_request(make_request(bpa_pkg::OP_MARK_FREE, 0, HOT_PAGES, 0));
        queue_request(make_request(bpa_pkg::OP_MARK_USED, 100, 10, 0));
        queue_request(make_request(bpa_pkg::OP_FREE, 'h5555, 'hAAAA, 0));

        repeat (RANDOM_ITEMS / 2)
            queue_request(random_request());

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender stops until every outstanding result is back
        while (results_seen != sent_total)
            @(posedge clk);
        repeat (RANDOM_ITEMS - RANDOM_ITEMS / 2)
            queue_request(random_request());

        while (results_seen != sent_total)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
